[hdl/tlmd_pkg.sv]
// shared types, constants and character helpers for the type-length deframer
// no dependencies
package tlmd_pkg;

   localparam int TYPE_CHARS = 4;
   localparam int HDR_BYTES  = 8;
   localparam int LEN_CHARS  = HDR_BYTES - TYPE_CHARS;

   localparam logic [7:0] CHR_PLUS  = 8'h2B;
   localparam logic [7:0] CHR_MINUS = 8'h2D;
   localparam logic [7:0] CHR_ZERO  = 8'h30;
   localparam logic [7:0] CHR_X_LO  = 8'h78;
   localparam logic [7:0] CHR_X_UP  = 8'h58;
   localparam logic [7:0] CHR_SPACE = 8'h20;

   typedef enum logic {
      FUNC_DATA    = 1'b0,
      FUNC_DISCARD = 1'b1
   } func_type;

   // input beat held in the input register
   typedef struct packed {
      logic       valid;
      logic       func;
      logic [7:0] data;
   } beat_type;

   // outcome of parsing the length characters
   typedef struct packed {
      logic        ok;
      logic [15:0] value;
   } len_parse_type;

   function automatic logic is_space(input logic [7:0] c);
      return (c == CHR_SPACE) || (c inside {[8'h09:8'h0D]});
   endfunction

   // bit 4 set when the character is a hex digit, low nibble its value
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c inside {[8'h30:8'h39]}) begin
         r = {1'b1, c[3:0]};
      end else if (c inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

[hdl/tlmd_len_parse.sv]
// combinational parser for the four hexadecimal length characters
// depends on tlmd_pkg
module tlmd_len_parse
   import tlmd_pkg::*;
(
   input  logic [31:0]   chars,
   output len_parse_type result
);

   logic [7:0]  c [LEN_CHARS];
   logic [3:0]  sp;
   logic        empty;
   logic        found;
   logic [2:0]  s_idx;
   logic [2:0]  e_idx;
   logic [2:0]  p_idx;
   logic [2:0]  d_idx;
   logic        neg;
   logic        bad;
   logic        any;
   logic [4:0]  hd;
   logic [15:0] v;

   always_comb begin
      for (int i = 0; i < LEN_CHARS; i++) begin
         c[i]  = chars[31 - 8*i -: 8];
         sp[i] = is_space(c[i]);
      end
      empty = &sp;

      // trim surrounding whitespace
      found = 1'b0;
      s_idx = 3'd0;
      e_idx = 3'd0;
      for (int i = 0; i < LEN_CHARS; i++) begin
         if (!sp[i] && !found) begin
            s_idx = 3'(i);
            found = 1'b1;
         end
         if (!sp[i]) begin
            e_idx = 3'(i);
         end
      end

      // optional sign
      p_idx = s_idx;
      neg   = 1'b0;
      if (c[s_idx[1:0]] == CHR_PLUS || c[s_idx[1:0]] == CHR_MINUS) begin
         p_idx = s_idx + 3'd1;
         neg   = (c[s_idx[1:0]] == CHR_MINUS);
      end

      // optional 0x prefix
      d_idx = p_idx;
      if ((p_idx + 3'd1 <= e_idx) && c[p_idx[1:0]] == CHR_ZERO &&
          (c[2'(p_idx + 3'd1)] == CHR_X_LO || c[2'(p_idx + 3'd1)] == CHR_X_UP)) begin
         d_idx = p_idx + 3'd2;
      end

      // digits
      bad = 1'b0;
      v   = 16'd0;
      hd  = 5'd0;
      for (int i = 0; i < LEN_CHARS; i++) begin
         hd = hex_decode(c[i]);
         if (3'(i) >= d_idx && 3'(i) <= e_idx) begin
            if (!hd[4]) begin
               bad = 1'b1;
            end
            v = {v[11:0], hd[3:0]};
         end
      end
      any = (d_idx <= e_idx);

      result.ok    = !empty && any && !bad && !(neg && v != 16'd0);
      result.value = v;
   end

endmodule

[hdl/tlmd_core.sv]
// deframing state and result register, one beat per cycle while results are not stalled
// depends on tlmd_pkg and tlmd_len_parse
module tlmd_core
   import tlmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  beat_type    beat,
   output logic        take,
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [31:0] rsp_msg_type,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_has_payload,
   output logic        rsp_first_of_msg,
   output logic        rsp_last_of_msg,
   output logic        rsp_header_error,
   output logic [15:0] rsp_msg_length
);

   logic [2:0]    hdr_cnt_ff,   hdr_cnt_in;
   logic [31:0]   type_ff,      type_in;
   logic [23:0]   len_chars_ff, len_chars_in;
   logic [15:0]   remain_ff,    remain_in;
   logic [15:0]   msg_len_ff,   msg_len_in;
   logic          first_ff,     first_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   type_out_ff,  type_out_in;
   logic [7:0]    byte_out_ff,  byte_out_in;
   logic          hasp_ff,      hasp_in;
   logic          fst_ff,       fst_in;
   logic          lst_ff,       lst_in;
   logic          err_ff,       err_in;
   logic [15:0]   len_out_ff,   len_out_in;

   logic          produce;
   len_parse_type parsed;

   tlmd_len_parse u_parse (
      .chars  ({len_chars_ff, beat.data}),
      .result (parsed)
   );

   assign take = beat.valid && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      hdr_cnt_in   = hdr_cnt_ff;
      type_in      = type_ff;
      len_chars_in = len_chars_ff;
      remain_in    = remain_ff;
      msg_len_in   = msg_len_ff;
      first_in     = first_ff;
      produce      = 1'b0;
      type_out_in  = type_ff;
      byte_out_in  = 8'd0;
      hasp_in      = 1'b0;
      fst_in       = 1'b1;
      lst_in       = 1'b1;
      err_in       = 1'b0;
      len_out_in   = 16'd0;

      if (take) begin
         if (beat.func == FUNC_DISCARD) begin
            hdr_cnt_in   = 3'd0;
            type_in      = 32'd0;
            len_chars_in = 24'd0;
            remain_in    = 16'd0;
            first_in     = 1'b0;
         end else if (remain_ff != 16'd0) begin
            produce     = 1'b1;
            byte_out_in = beat.data;
            hasp_in     = 1'b1;
            fst_in      = first_ff;
            lst_in      = (remain_ff == 16'd1);
            len_out_in  = msg_len_ff;
            remain_in   = remain_ff - 16'd1;
            first_in    = 1'b0;
         end else begin
            if (hdr_cnt_ff < 3'(TYPE_CHARS)) begin
               type_in = {type_ff[23:0], beat.data};
            end else begin
               len_chars_in = {len_chars_ff[15:0], beat.data};
            end
            if (hdr_cnt_ff == 3'(HDR_BYTES - 1)) begin
               hdr_cnt_in = 3'd0;
               if (!parsed.ok) begin
                  produce  = 1'b1;
                  err_in   = 1'b1;
                  first_in = 1'b0;
               end else if (parsed.value == 16'd0) begin
                  produce  = 1'b1;
                  first_in = 1'b0;
               end else begin
                  remain_in  = parsed.value;
                  msg_len_in = parsed.value;
                  first_in   = 1'b1;
               end
            end else begin
               hdr_cnt_in = hdr_cnt_ff + 3'd1;
            end
         end
      end

      if (take) begin
         rsp_valid_in = produce;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_cnt_ff   <= 3'd0;
         type_ff      <= 32'd0;
         len_chars_ff <= 24'd0;
         remain_ff    <= 16'd0;
         first_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         hdr_cnt_ff   <= hdr_cnt_in;
         type_ff      <= type_in;
         len_chars_ff <= len_chars_in;
         remain_ff    <= remain_in;
         first_ff     <= first_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      msg_len_ff <= msg_len_in;
      if (produce) begin
         type_out_ff <= type_out_in;
         byte_out_ff <= byte_out_in;
         hasp_ff     <= hasp_in;
         fst_ff      <= fst_in;
         lst_ff      <= lst_in;
         err_ff      <= err_in;
         len_out_ff  <= len_out_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_msg_type     = type_out_ff;
   assign rsp_payload_byte = byte_out_ff;
   assign rsp_has_payload  = hasp_ff;
   assign rsp_first_of_msg = fst_ff;
   assign rsp_last_of_msg  = lst_ff;
   assign rsp_header_error = err_ff;
   assign rsp_msg_length   = len_out_ff;

endmodule

[hdl/type_length_message_deframer_top.sv]
// a byte passes the input register, then its result is held in the core's result register
// throughput: one byte per cycle while results are taken
// an input register takes the next byte while a result waits to be taken
// reset (synchronous, active high) clears the header count, message state and
// both valid flags; payload registers are not reset
module type_length_message_deframer_top
   import tlmd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_func,
   input  logic [7:0]  req_in_byte,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [31:0] rsp_msg_type,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_has_payload,
   output logic        rsp_first_of_msg,
   output logic        rsp_last_of_msg,
   output logic        rsp_header_error,
   output logic [15:0] rsp_msg_length
);

   logic       in_valid_ff, in_valid_in;
   logic       in_func_ff;
   logic [7:0] in_byte_ff;
   logic       take;
   logic       accept;
   beat_type   beat;

   assign req_stall = in_valid_ff && !take;
   assign accept    = req_valid && !req_stall;

   always_comb begin
      if (accept) begin
         in_valid_in = 1'b1;
      end else if (take) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_func_ff <= req_func;
         in_byte_ff <= req_in_byte;
      end
   end

   assign beat.valid = in_valid_ff;
   assign beat.func  = in_func_ff;
   assign beat.data  = in_byte_ff;

   tlmd_core u_core (
      .clock            (clock),
      .reset            (reset),
      .beat             (beat),
      .take             (take),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_msg_type     (rsp_msg_type),
      .rsp_payload_byte (rsp_payload_byte),
      .rsp_has_payload  (rsp_has_payload),
      .rsp_first_of_msg (rsp_first_of_msg),
      .rsp_last_of_msg  (rsp_last_of_msg),
      .rsp_header_error (rsp_header_error),
      .rsp_msg_length   (rsp_msg_length)
   );

endmodule
